[hw/rtl/segment_box_overlap_test_top_macros.svh]
// Assertion macros shared by the segment and box overlap tester RTL.
`ifndef SEGMENT_BOX_OVERLAP_TEST_TOP_MACROS_SVH
`define SEGMENT_BOX_OVERLAP_TEST_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBOT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbot assertion failed");

// Next-cycle implication, disabled during reset.
`define SBOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbot assertion failed");

`endif

[hw/rtl/sbot_pkg.sv]
// Shared widths, command codes and types for the segment and box overlap tester.
package sbot_pkg;

	localparam int COORD_BITS = 31;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;

	typedef enum logic [1:0] {
		CMD_SEG_SEG = 2'd0,
		CMD_SEG_BOX = 2'd1,
		CMD_BOX_BOX = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// Sign of an orientation: pos and neg never both set, neither means collinear.
	typedef struct packed {
		logic pos;
		logic neg;
	} turn_t;

endpackage

[hw/rtl/segment_box_overlap_test_top.sv]
// Segment/box overlap tester: four-stage pipeline, one transaction per clock.
// done and hit are registered in stage s4, behind the orientation-unit stages s1 to s3.
// Throughput: one transaction per cycle; eight orientation units run in parallel.
// busy is always low since results cannot be held off and nothing recirculates.
// Reset (arst_n low, asynchronous) clears every valid bit; transactions in flight are dropped.
`include "segment_box_overlap_test_top_macros.svh"

module segment_box_overlap_test_top (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic [1:0]                               command,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   a_x0,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   a_y0,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   a_x1,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   a_y1,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   b_x0,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   b_y0,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   b_x1,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   b_y1,
	output logic                                     done,
	output logic                                     hit
);

	logic            accept;
	logic            in_a0, in_a1, box_ovl;
	logic            valid_s1, valid_s2, valid_s3, done_s4;
	sbot_pkg::cmd_t  cmd_s1, cmd_s2, cmd_s3;
	logic            in0_s1, in1_s1, ovl_s1;
	logic            in0_s2, in1_s2, ovl_s2;
	logic            in0_s3, in1_s3, ovl_s3;
	logic            hit_s4, hit_d;
	logic [1:0]      diag_cross;

	// Per diagonal: turns of A's ends against the diagonal, and of its ends against A.
	sbot_pkg::turn_t t_p0 [2];
	sbot_pkg::turn_t t_p1 [2];
	sbot_pkg::turn_t t_q0 [2];
	sbot_pkg::turn_t t_q1 [2];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Closed-box containment of A's endpoints and interval overlap of the two boxes.
	assign in_a0   = (b_x0 <= a_x0) && (b_x1 >= a_x0) && (b_y0 <= a_y0) && (b_y1 >= a_y0);
	assign in_a1   = (b_x0 <= a_x1) && (b_x1 >= a_x1) && (b_y0 <= a_y1) && (b_y1 >= a_y1);
	assign box_ovl = (b_x0 <= a_x1) && (b_y0 <= a_y1) && (b_x1 >= a_x0) && (b_y1 >= a_y0);

	// Diagonal 0 runs (b_x0,b_y0)-(b_x1,b_y1); diagonal 1 runs (b_x0,b_y1)-(b_x1,b_y0).
	// For segment-segment, diagonal 0 is segment B itself.
	for (genvar d = 0; d < 2; d++) begin : g_diag
		logic signed [sbot_pkg::COORD_BITS-1:0] q0y, q1y;

		assign q0y = (d == 0) ? b_y0 : b_y1;
		assign q1y = (d == 0) ? b_y1 : b_y0;

		sbot_turn u_turn_p0 (
			.clk(clk), .px(a_x0), .py(a_y0), .qx(b_x0), .qy(q0y),
			.rx(b_x1), .ry(q1y), .turn(t_p0[d])
		);
		sbot_turn u_turn_p1 (
			.clk(clk), .px(a_x1), .py(a_y1), .qx(b_x0), .qy(q0y),
			.rx(b_x1), .ry(q1y), .turn(t_p1[d])
		);
		sbot_turn u_turn_q0 (
			.clk(clk), .px(a_x0), .py(a_y0), .qx(a_x1), .qy(a_y1),
			.rx(b_x0), .ry(q0y), .turn(t_q0[d])
		);
		sbot_turn u_turn_q1 (
			.clk(clk), .px(a_x0), .py(a_y0), .qx(a_x1), .qy(a_y1),
			.rx(b_x1), .ry(q1y), .turn(t_q1[d])
		);

		assign diag_cross[d] = (t_p0[d] != t_p1[d]) && (t_q0[d] != t_q1[d]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_s4  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_s4  <= valid_s3;
		end
	end

	// Side data follows the orientation units stage for stage.
	always_ff @(posedge clk) begin
		cmd_s1 <= sbot_pkg::cmd_t'(command);
		in0_s1 <= in_a0;
		in1_s1 <= in_a1;
		ovl_s1 <= box_ovl;
		cmd_s2 <= cmd_s1;
		in0_s2 <= in0_s1;
		in1_s2 <= in1_s1;
		ovl_s2 <= ovl_s1;
		cmd_s3 <= cmd_s2;
		in0_s3 <= in0_s2;
		in1_s3 <= in1_s2;
		ovl_s3 <= ovl_s2;
		hit_s4 <= hit_d;
	end

	always_comb begin
		unique case (cmd_s3)
			sbot_pkg::CMD_SEG_SEG: hit_d = diag_cross[0];
			sbot_pkg::CMD_SEG_BOX: hit_d = in0_s3 || in1_s3 || diag_cross[0] || diag_cross[1];
			sbot_pkg::CMD_BOX_BOX: hit_d = ovl_s3;
			default:               hit_d = 1'b0;
		endcase
	end

	assign done = done_s4;
	assign hit  = hit_s4;

	`SBOT_ASSERT_NEXT(a_accept_enters, clk, arst_n, accept, valid_s1)
	`SBOT_ASSERT_NEXT(a_strobe_follows, clk, arst_n, valid_s3, done)
	`SBOT_ASSERT_NEXT(a_unused_no_hit, clk, arst_n, valid_s3 && (cmd_s3 == sbot_pkg::CMD_NONE), !hit)
	`SBOT_ASSERT_NEXT(a_endpoint_hit, clk, arst_n, valid_s3 && (cmd_s3 == sbot_pkg::CMD_SEG_BOX) && (in0_s3 || in1_s3), hit)
	`SBOT_ASSERT_IMP(a_turn_sign, clk, arst_n, valid_s3, !(t_p0[0].pos && t_p0[0].neg))

endmodule

[hw/rtl/sbot_turn.sv]
// Three-stage orientation unit: differences, exact products, sign compare.
module sbot_turn (
	input  logic                                     clk,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   px,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   py,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   qx,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   qy,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   rx,
	input  logic signed [sbot_pkg::COORD_BITS-1:0]   ry,
	output sbot_pkg::turn_t                          turn
);

	logic signed [sbot_pkg::DIFF_BITS-1:0] drx_s1, dqy_s1, dqx_s1, dry_s1;
	logic signed [sbot_pkg::PROD_BITS-1:0] u_s2, w_s2;
	sbot_pkg::turn_t                       turn_s3;

	// Differences are one bit wider than coordinates, so they never wrap.
	always_ff @(posedge clk) begin
		drx_s1 <= sbot_pkg::DIFF_BITS'(rx) - sbot_pkg::DIFF_BITS'(px);
		dqy_s1 <= sbot_pkg::DIFF_BITS'(qy) - sbot_pkg::DIFF_BITS'(py);
		dqx_s1 <= sbot_pkg::DIFF_BITS'(qx) - sbot_pkg::DIFF_BITS'(px);
		dry_s1 <= sbot_pkg::DIFF_BITS'(ry) - sbot_pkg::DIFF_BITS'(py);
	end

	always_ff @(posedge clk) begin
		u_s2 <= sbot_pkg::PROD_BITS'(drx_s1) * sbot_pkg::PROD_BITS'(dqy_s1);
		w_s2 <= sbot_pkg::PROD_BITS'(dqx_s1) * sbot_pkg::PROD_BITS'(dry_s1);
	end

	always_ff @(posedge clk) begin
		turn_s3.pos <= (u_s2 > w_s2);
		turn_s3.neg <= (u_s2 < w_s2);
	end

	assign turn = turn_s3;

endmodule
